FILE: design/lpd_pkg.sv
// shared types and constants for the 3x3 local peak detector
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int MAX_COLS_DEF    = 128;
  localparam int MAX_ROWS_DEF    = 128;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_ROWS = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COLS = 8'd1;

  localparam int NUM_BANKS = 3;
  localparam int NUM_SLOTS = 4;

  // decision slots in emit order
  localparam int SLOT_UL = 0;
  localparam int SLOT_UR = 1;
  localparam int SLOT_LL = 2;
  localparam int SLOT_LR = 3;

  typedef logic [1:0] bank_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nb_mask_t;

endpackage

FILE: design/local_peak_detect_3x3.sv
// top level: 3x3 local peak detector on a raster sample stream
// pipeline: an accepted sample passes stage one, its peaks wait in the hold stage and leave through the result register
// throughput: one sample per cycle while each sample decides at most one peak and out_ready is high;
//   a sample deciding several peaks holds the input while the hold stage drains them one by one
// reset: synchronous rst_n clears pipeline control and frame position, sets a 1x1 frame;
//   the line stores are not cleared and need no clearing pass
`timescale 1ns / 1ps

module local_peak_detect_3x3 #(
  parameter int MAX_COLS    = lpd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = lpd_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = lpd_pkg::SAMPLE_BITS_DEF,
  localparam int COL_BITS   = $clog2(MAX_COLS),
  localparam int ROW_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ROW_BITS-1:0]               out_peak_row,
  output logic [COL_BITS-1:0]               out_peak_col,
  output logic signed [SAMPLE_BITS-1:0]     out_peak_value,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  import lpd_pkg::*;

  // configuration
  logic [ROW_BITS-1:0] rows_lim_r, rows_lim_nxt;
  logic [COL_BITS-1:0] cols_lim_r, cols_lim_nxt;
  logic                cfg_wr, cfg_rows_hit, cfg_cols_hit;

  // frame position
  logic [ROW_BITS-1:0] row_pos_r, row_pos_nxt;
  logic [COL_BITS-1:0] col_pos_r, col_pos_nxt;
  bank_t               bank_r, bank_nxt, bank_inc;
  logic                at_last_row, at_last_col;

  // stage 1
  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [ROW_BITS-1:0]           s1_row_r;
  logic [COL_BITS-1:0]           s1_col_r;
  logic                          s1_last_row_r, s1_last_col_r;
  bank_t                         s1_bank_r;

  // window columns c-1 and c-2, rows top / mid / current
  logic signed [SAMPLE_BITS-1:0] w1_top_r, w1_mid_r, w1_cur_r;
  logic signed [SAMPLE_BITS-1:0] w2_top_r, w2_mid_r, w2_cur_r;

  // hold stage
  logic [NUM_SLOTS-1:0]          pend_mask_r, pend_mask_nxt;
  logic [ROW_BITS-1:0]           pend_row_r [NUM_SLOTS];
  logic [COL_BITS-1:0]           pend_col_r [NUM_SLOTS];
  logic signed [SAMPLE_BITS-1:0] pend_val_r [NUM_SLOTS];

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [ROW_BITS-1:0]           out_row_r;
  logic [COL_BITS-1:0]           out_col_r;
  logic signed [SAMPLE_BITS-1:0] out_val_r;
  logic                          out_last_r;

  logic accept, s1_adv, out_free, take, pend_any, pend_multi, pend_can_load;

  // line stores
  logic [NUM_BANKS-1:0]   bank_we;
  logic [SAMPLE_BITS-1:0] bank_rd [NUM_BANKS];
  logic signed [SAMPLE_BITS-1:0] top_rd, mid_rd;

  // peak tests
  logic signed [SAMPLE_BITS-1:0] win_ul [3][3];
  logic signed [SAMPLE_BITS-1:0] win_ur [3][3];
  logic signed [SAMPLE_BITS-1:0] win_ll [3][3];
  logic signed [SAMPLE_BITS-1:0] win_lr [3][3];
  nb_mask_t             mask_ul, mask_ur, mask_ll, mask_lr;
  logic [NUM_SLOTS-1:0] peak_hit, slot_en, hit_mask;
  logic                 r_ge1, r_ge2, c_ge1, c_ge2;

  logic [NUM_SLOTS-1:0] first_one, pend_rest;
  logic [1:0]           first_idx;

  // configuration port
  assign cfg_ready    = 1'b1;
  assign cfg_wr       = cfg_valid && cfg_ready;
  assign cfg_rows_hit = cfg_wr && (cfg_index == CFG_FRAME_ROWS);
  assign cfg_cols_hit = cfg_wr && (cfg_index == CFG_FRAME_COLS);

  always_comb begin
    rows_lim_nxt = rows_lim_r;
    cols_lim_nxt = cols_lim_r;
    if (cfg_rows_hit) begin
      if (cfg_data == '0) begin
        rows_lim_nxt = '0;
      end else if (32'(cfg_data) > MAX_ROWS) begin
        rows_lim_nxt = ROW_BITS'(MAX_ROWS - 1);
      end else begin
        rows_lim_nxt = ROW_BITS'(cfg_data - 8'd1);
      end
    end
    if (cfg_cols_hit) begin
      if (cfg_data == '0) begin
        cols_lim_nxt = '0;
      end else if (32'(cfg_data) > MAX_COLS) begin
        cols_lim_nxt = COL_BITS'(MAX_COLS - 1);
      end else begin
        cols_lim_nxt = COL_BITS'(cfg_data - 8'd1);
      end
    end
  end

  // handshakes
  assign out_free      = !out_valid_r || out_ready;
  assign pend_any      = (pend_mask_r != '0);
  assign pend_multi    = ($countones(pend_mask_r) > 1);
  assign take          = pend_any && out_free;
  assign pend_can_load = !pend_any || (take && !pend_multi);
  assign s1_adv        = s1_valid_r && pend_can_load;
  assign in_ready      = !s1_valid_r || pend_can_load;
  assign accept        = in_valid && in_ready;

  // frame position
  assign at_last_row = (row_pos_r == rows_lim_r);
  assign at_last_col = (col_pos_r == cols_lim_r);

  always_comb begin
    case (bank_r)
      2'd0:    bank_inc = 2'd1;
      2'd1:    bank_inc = 2'd2;
      default: bank_inc = 2'd0;
    endcase
  end

  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    bank_nxt    = bank_r;
    if (cfg_rows_hit || cfg_cols_hit) begin
      row_pos_nxt = '0;
      col_pos_nxt = '0;
      bank_nxt    = '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_pos_nxt = '0;
        if (at_last_row) begin
          row_pos_nxt = '0;
          bank_nxt    = '0;
        end else begin
          row_pos_nxt = row_pos_r + 1'b1;
          bank_nxt    = bank_inc;
        end
      end else begin
        col_pos_nxt = col_pos_r + 1'b1;
      end
    end
  end

  // line store banks, row r goes to bank r mod 3
  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    assign bank_we[k] = accept && (bank_r == bank_t'(k));
    lpd_line_ram #(
      .DEPTH (MAX_COLS),
      .WIDTH (SAMPLE_BITS)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[k]),
      .waddr (col_pos_r),
      .wdata (in_sample),
      .re    (accept),
      .raddr (col_pos_r),
      .rdata (bank_rd[k])
    );
  end

  always_comb begin
    case (s1_bank_r)
      2'd0: begin
        mid_rd = bank_rd[2];
        top_rd = bank_rd[1];
      end
      2'd1: begin
        mid_rd = bank_rd[0];
        top_rd = bank_rd[2];
      end
      default: begin
        mid_rd = bank_rd[1];
        top_rd = bank_rd[0];
      end
    endcase
  end

  // window assembly
  assign r_ge1 = (s1_row_r != '0);
  assign r_ge2 = (s1_row_r > ROW_BITS'(1));
  assign c_ge1 = (s1_col_r != '0);
  assign c_ge2 = (s1_col_r > COL_BITS'(1));

  always_comb begin
    win_ul = '{'{w2_top_r, w1_top_r, top_rd},
               '{w2_mid_r, w1_mid_r, mid_rd},
               '{w2_cur_r, w1_cur_r, s1_sample_r}};
    win_ur = '{'{w1_top_r, top_rd, '0},
               '{w1_mid_r, mid_rd, '0},
               '{w1_cur_r, s1_sample_r, '0}};
    win_ll = '{'{w2_mid_r, w1_mid_r, mid_rd},
               '{w2_cur_r, w1_cur_r, s1_sample_r},
               '{'0, '0, '0}};
    win_lr = '{'{w1_mid_r, mid_rd, '0},
               '{w1_cur_r, s1_sample_r, '0},
               '{'0, '0, '0}};
  end

  assign mask_ul = '{up: r_ge2, down: 1'b1, left: c_ge2, right: 1'b1};
  assign mask_ur = '{up: r_ge2, down: 1'b1, left: c_ge1, right: 1'b0};
  assign mask_ll = '{up: r_ge1, down: 1'b0, left: c_ge2, right: 1'b1};
  assign mask_lr = '{up: r_ge1, down: 1'b0, left: c_ge1, right: 1'b0};

  lpd_peak_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_peak_ul (
    .win (win_ul), .mask (mask_ul), .peak (peak_hit[SLOT_UL])
  );
  lpd_peak_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_peak_ur (
    .win (win_ur), .mask (mask_ur), .peak (peak_hit[SLOT_UR])
  );
  lpd_peak_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_peak_ll (
    .win (win_ll), .mask (mask_ll), .peak (peak_hit[SLOT_LL])
  );
  lpd_peak_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_peak_lr (
    .win (win_lr), .mask (mask_lr), .peak (peak_hit[SLOT_LR])
  );

  assign slot_en[SLOT_UL] = r_ge1 && c_ge1;
  assign slot_en[SLOT_UR] = r_ge1 && s1_last_col_r;
  assign slot_en[SLOT_LL] = s1_last_row_r && c_ge1;
  assign slot_en[SLOT_LR] = s1_last_row_r && s1_last_col_r;
  assign hit_mask         = slot_en & peak_hit;

  // first pending slot
  assign first_one = pend_mask_r & (~pend_mask_r + 1'b1);
  assign pend_rest = pend_mask_r & ~first_one;

  always_comb begin
    first_idx = 2'd0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_mask_r[i]) begin
        first_idx = 2'(i);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    pend_mask_nxt = pend_mask_r;
    if (s1_adv) begin
      pend_mask_nxt = hit_mask;
    end else if (take) begin
      pend_mask_nxt = pend_rest;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_lim_r  <= '0;
      cols_lim_r  <= '0;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      bank_r      <= '0;
      s1_valid_r  <= 1'b0;
      pend_mask_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rows_lim_r  <= rows_lim_nxt;
      cols_lim_r  <= cols_lim_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      bank_r      <= bank_nxt;
      s1_valid_r  <= s1_valid_nxt;
      pend_mask_r <= pend_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r   <= in_sample;
      s1_row_r      <= row_pos_r;
      s1_col_r      <= col_pos_r;
      s1_last_row_r <= at_last_row;
      s1_last_col_r <= at_last_col;
      s1_bank_r     <= bank_r;
    end
    if (s1_adv) begin
      w2_top_r <= w1_top_r;
      w2_mid_r <= w1_mid_r;
      w2_cur_r <= w1_cur_r;
      w1_top_r <= top_rd;
      w1_mid_r <= mid_rd;
      w1_cur_r <= s1_sample_r;
      pend_row_r[SLOT_UL] <= s1_row_r - 1'b1;
      pend_col_r[SLOT_UL] <= s1_col_r - 1'b1;
      pend_val_r[SLOT_UL] <= w1_mid_r;
      pend_row_r[SLOT_UR] <= s1_row_r - 1'b1;
      pend_col_r[SLOT_UR] <= s1_col_r;
      pend_val_r[SLOT_UR] <= mid_rd;
      pend_row_r[SLOT_LL] <= s1_row_r;
      pend_col_r[SLOT_LL] <= s1_col_r - 1'b1;
      pend_val_r[SLOT_LL] <= w1_cur_r;
      pend_row_r[SLOT_LR] <= s1_row_r;
      pend_col_r[SLOT_LR] <= s1_col_r;
      pend_val_r[SLOT_LR] <= s1_sample_r;
    end
    if (take) begin
      out_row_r  <= pend_row_r[first_idx];
      out_col_r  <= pend_col_r[first_idx];
      out_val_r  <= pend_val_r[first_idx];
      out_last_r <= (pend_rest == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_peak_row    = out_row_r;
  assign out_peak_col    = out_col_r;
  assign out_peak_value  = out_val_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (row_pos_r <= rows_lim_r) && (col_pos_r <= cols_lim_r))
    else $error("frame position outside configured frame");

  a_bank_at_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (row_pos_r == '0) |-> (bank_r == '0))
    else $error("line store bank out of step with row");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted transaction lost before stage one");

  a_take_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("pending peak dropped on its way to the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> (!pend_multi))
    else $error("hold stage overwritten while results still pending");
`endif

endmodule

FILE: design/lpd_line_ram.sv
// one line store bank, registered read
`timescale 1ns / 1ps

module lpd_line_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lpd_peak_cell.sv
// strict eight-neighbour maximum test over one 3x3 window
`timescale 1ns / 1ps

module lpd_peak_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] win [3][3],
  input  lpd_pkg::nb_mask_t             mask,
  output logic                          peak
);

  import lpd_pkg::*;

  always_comb begin
    logic present;
    peak = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        present = (i != 0 || mask.up) && (i != 2 || mask.down) &&
                  (j != 0 || mask.left) && (j != 2 || mask.right) &&
                  !(i == 1 && j == 1);
        if (present && !(win[1][1] > win[i][j])) begin
          peak = 1'b0;
        end
      end
    end
  end

endmodule

FILE: tb/sv/local_peak_detect_3x3_tb.sv
// self-checking testbench for the 3x3 local peak detector
`timescale 1ns / 1ps

module local_peak_detect_3x3_tb;

  localparam int MAX_COLS       = lpd_pkg::MAX_COLS_DEF;
  localparam int MAX_ROWS       = lpd_pkg::MAX_ROWS_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [lpd_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 8'hFE;

  localparam int VALUES_FULL    = 0;
  localparam int VALUES_NARROW  = 1;
  localparam int VALUES_EXTREME = 2;

  typedef struct packed {
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] value;
    logic               last;
  } peak_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [15:0]                  in_sample;
  logic                                out_valid;
  logic                                out_ready;
  logic [6:0]                          out_peak_row;
  logic [6:0]                          out_peak_col;
  logic signed [15:0]                  out_peak_value;
  logic                                out_last_of_run;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [lpd_pkg::CFG_IDX_BITS-1:0]    cfg_index;
  logic [lpd_pkg::CFG_DATA_BITS-1:0]   cfg_data;

  // peak predictor state
  logic signed [15:0] line_store [0:2][0:MAX_COLS-1];
  int                 next_row;
  int                 next_col;
  logic [7:0]         rows_reg;
  logic [7:0]         cols_reg;

  peak_t pending_peaks [$];
  peak_t want_peak;
  int    mismatch_count;
  int    idle_cycles;
  int    send_idle_pct;
  int    recv_idle_pct;

  local_peak_detect_3x3 DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_peak_value  (out_peak_value),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function automatic bit is_local_max(input int r, input int c, input int rows, input int cols);
    logic signed [15:0] centre;
    int nr;
    int nc;
    bit peak;
    centre = line_store[r % 3][c];
    peak = 1'b1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = r + dr;
        nc = c + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
          if (centre <= line_store[nr % 3][nc]) peak = 1'b0;
        end
      end
    end
    return peak;
  endfunction

  function automatic peak_t make_peak(input int r, input int c);
    peak_t p;
    p.row   = r[6:0];
    p.col   = c[6:0];
    p.value = line_store[r % 3][c];
    p.last  = 1'b0;
    return p;
  endfunction

  task automatic predict_peaks(input logic signed [15:0] value);
    int    rows;
    int    cols;
    int    r;
    int    c;
    int    n;
    bit    last_col;
    bit    last_row;
    peak_t found [4];
    rows = active_rows();
    cols = active_cols();
    r = next_row;
    c = next_col;
    if (r >= rows) r = 0;
    if (c >= cols) c = 0;
    line_store[r % 3][c] = value;
    last_col = (c + 1 == cols);
    last_row = (r + 1 == rows);
    n = 0;
    if (r >= 1 && c >= 1 && is_local_max(r - 1, c - 1, rows, cols)) begin
      found[n] = make_peak(r - 1, c - 1);
      n++;
    end
    if (r >= 1 && last_col && is_local_max(r - 1, c, rows, cols)) begin
      found[n] = make_peak(r - 1, c);
      n++;
    end
    if (last_row && c >= 1 && is_local_max(r, c - 1, rows, cols)) begin
      found[n] = make_peak(r, c - 1);
      n++;
    end
    if (last_row && last_col && is_local_max(r, c, rows, cols)) begin
      found[n] = make_peak(r, c);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      pending_peaks.push_back(found[i]);
    end
    if (last_col) begin
      next_col = 0;
      next_row = last_row ? 0 : r + 1;
    end else begin
      next_row = r;
      next_col = c + 1;
    end
  endtask

  task automatic send_sample(input logic signed [15:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_peaks(value);
  endtask

  // stop the stream and let every outstanding transaction complete
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [lpd_pkg::CFG_IDX_BITS-1:0] index,
                                input logic [lpd_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == lpd_pkg::CFG_FRAME_ROWS) begin
      rows_reg = data;
      next_row = 0;
      next_col = 0;
    end else if (index == lpd_pkg::CFG_FRAME_COLS) begin
      cols_reg = data;
      next_row = 0;
      next_col = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [7:0] rows, input logic [7:0] cols);
    settle_block();
    if ($urandom_range(1) == 0) begin
      write_register(lpd_pkg::CFG_FRAME_ROWS, rows);
      write_register(lpd_pkg::CFG_FRAME_COLS, cols);
    end else begin
      write_register(lpd_pkg::CFG_FRAME_COLS, cols);
      write_register(lpd_pkg::CFG_FRAME_ROWS, rows);
    end
  endtask

  function automatic logic signed [15:0] random_sample(input int mode);
    logic signed [15:0] v;
    v = 16'($urandom);
    if (mode == VALUES_NARROW) begin
      v = 16'($urandom_range(4));
      v = v - 16'sd2;
    end else if (mode == VALUES_EXTREME) begin
      case ($urandom_range(3))
        0: v = 16'sh8000;
        1: v = 16'sh7FFF;
        2: v = -16'sd1;
        default: v = 16'sd0;
      endcase
    end
    return v;
  endfunction

  task automatic test_reset_frame();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
  endtask

  task automatic test_zero_size();
    set_frame(8'd0, 8'd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
  endtask

  task automatic test_plateau();
    set_frame(8'd2, 8'd3);
    repeat (6) send_sample(16'sd7);
  endtask

  task automatic test_extreme_peak();
    set_frame(8'd3, 8'd3);
    for (int i = 0; i < 9; i++) begin
      send_sample((i == 4) ? 16'sh7FFF : 16'sh8000);
    end
  endtask

  task automatic test_frame_restart();
    set_frame(8'd2, 8'd2);
    send_sample(16'sd10);
    send_sample(16'sd20);
    // unknown index leaves the frame position alone
    settle_block();
    write_register(CFG_UNUSED_INDEX, 8'hFF);
    send_sample(16'sd30);
    // a register write drops the partial frame
    settle_block();
    write_register(lpd_pkg::CFG_FRAME_COLS, 8'd2);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    send_sample(-16'sd6);
    send_sample(-16'sd7);
  endtask

  task automatic test_tallest_frame();
    set_frame(8'd255, 8'd1);
    repeat (40) send_sample(random_sample(VALUES_FULL));
  endtask

  task automatic test_widest_frame();
    set_frame(8'd1, 8'd128);
    repeat (128) send_sample(random_sample(VALUES_FULL));
  endtask

  task automatic test_random_frames(input int target_items);
    int sent;
    int rows;
    int cols;
    int count;
    int mode;
    logic [7:0] rows_val;
    logic [7:0] cols_val;
    sent = 0;
    while (sent < target_items) begin
      rows_val = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      cols_val = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
      set_frame(rows_val, cols_val);
      if ($urandom_range(5) == 0) write_register(8'($urandom_range(2, 255)), 8'($urandom));
      rows = active_rows();
      cols = active_cols();
      count = rows * cols;
      case ($urandom_range(4))
        0: count = (count > 1) ? $urandom_range(1, count - 1) : 1;
        1: count = 2 * count;
        default: ;
      endcase
      mode = $urandom_range(VALUES_EXTREME);
      repeat (count) send_sample(random_sample(mode));
      sent += count;
    end
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (pending_peaks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected peak: row %0d col %0d value %0d last %0b", out_peak_row,
                     out_peak_col, out_peak_value, out_last_of_run);
        end else begin
          want_peak = pending_peaks.pop_front();
          if (out_peak_row !== want_peak.row || out_peak_col !== want_peak.col ||
              out_peak_value !== want_peak.value || out_last_of_run !== want_peak.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("peak mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                       want_peak.row, want_peak.col, $signed(want_peak.value), want_peak.last,
                       out_peak_row, out_peak_col, out_peak_value, out_last_of_run);
          end
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample      = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    next_row       = 0;
    next_col       = 0;
    rows_reg       = 8'd1;
    cols_reg       = 8'd1;
    send_idle_pct  = 27;
    recv_idle_pct  = 60;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_frame();
    test_zero_size();
    test_plateau();
    test_extreme_peak();
    test_frame_restart();
    test_tallest_frame();
    test_random_frames(35);

    settle_block();
    send_idle_pct = 60;
    recv_idle_pct = 27;
    test_random_frames(40);

    settle_block();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_widest_frame();
    test_random_frames(35);

    settle_block();
    mismatch_count += pending_peaks.size();
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
